[hdl/two_wire_debug_host_master_core_assert.svh]
// Assertion macros shared by the debug host modules.
// Each macro needs clk and rst in scope at the place of use.
`ifndef TWO_WIRE_DEBUG_HOST_MASTER_CORE_ASSERT_SVH
`define TWO_WIRE_DEBUG_HOST_MASTER_CORE_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define TWDH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds at the next clock edge.
`define TWDH_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[hdl/twdh_pkg.sv]
package twdh_pkg;

  localparam int ADDR_BITS = 7;
  localparam int DATA_BITS = 32;
  localparam int RESET_CLOCKS_DEF = 100;

  // Bit positions within a write or read frame.
  localparam int DATA_FIRST = ADDR_BITS + 7;
  localparam int DATA_PAR = DATA_FIRST + DATA_BITS;
  localparam int TRAILER_LOW = DATA_PAR + 2;
  localparam int TOTAL_BITS = DATA_PAR + 6;

  localparam int TPU_W = 16;
  localparam int HBU_W = 4;
  localparam int TICK_W = TPU_W + HBU_W;
  localparam int ADDR_IDX_W = $clog2(ADDR_BITS);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TPU_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_UNITS = 2'd1;

  localparam logic [TPU_W-1:0] TPU_RESET = 16'd1;
  localparam logic [HBU_W-1:0] HBU_RESET = 4'd2;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_START_C  = 4'd3,
    PH_BIT_LOW  = 4'd4,
    PH_BIT_HIGH = 4'd5,
    PH_RST_PRE  = 4'd6,
    PH_RST_LOW  = 4'd7,
    PH_RST_HIGH = 4'd8,
    PH_STOP_A   = 4'd9,
    PH_STOP_B   = 4'd10,
    PH_STOP_C   = 4'd11
  } phase_t;

  // One classified tick as it travels from the front to the sequencer.
  typedef struct packed {
    logic                 start;
    kind_t                kind;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] wdata;
    logic                 sample;
  } item_t;

endpackage

[hdl/two_wire_debug_host_master_core.sv]
// Host side of a two-wire debug link, stepped one clock tick of the pin
// sequencer per input beat. Every input beat gives exactly one result beat with
// the clock line level, the data line drive (low or released), busy, a done
// pulse, the word of the last completed read and the status of the last
// completed transaction (read parity, zero after a write or reset). A request
// with start_req set is honoured only while the link is idle: command 0 writes,
// 1 reads, 2 sends a line reset of RESET_CLOCKS clocks; command 3 is dropped.
// The block sustains one beat per cycle while the result port is not stalled.
// An accepted beat passes through the front classifier into a two-entry queue,
// and the back sequencer then steps its state and loads the result register.
// The queue and the result register let each side stall on its own without
// losing beats. Timing is set through the configuration port: register 0 holds
// ticks per timing unit, register 1 holds units per clock half-period of a data
// bit; a zero in either acts as one. Configuration is expected only while the
// link is idle and no beats are in flight; cfg_ready is always high.
module two_wire_debug_host_master_core import twdh_pkg::*; #(
  parameter int RESET_CLOCKS = RESET_CLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Tick beats in.
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  start_req,
  input  logic [1:0]            cmd,
  input  logic [ADDR_BITS-1:0]  reg_addr,
  input  logic [DATA_BITS-1:0]  write_data,
  input  logic                  line_sample,
  // Result beats out.
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  clock_level,
  output logic                  data_drive_low,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [DATA_BITS-1:0]  read_data,
  output logic                  status
);

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  // Front: takes beats and flags real transaction requests.
  twdh_front u_front (
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .start_req   (start_req),
    .cmd         (cmd),
    .reg_addr    (reg_addr),
    .write_data  (write_data),
    .line_sample (line_sample),
    .q_full      (q_full),
    .push        (push),
    .item        (push_item)
  );

  // Short queue that decouples input acceptance from the sequencer.
  twdh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Back: pin sequencer, timing registers and the result register.
  twdh_back #(
    .RESET_CLOCKS (RESET_CLOCKS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .clock_level    (clock_level),
    .data_drive_low (data_drive_low),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .read_data      (read_data),
    .status         (status)
  );

endmodule

[hdl/twdh_front.sv]
module twdh_front import twdh_pkg::*; (
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 start_req,
  input  logic [1:0]           cmd,
  input  logic [ADDR_BITS-1:0] reg_addr,
  input  logic [DATA_BITS-1:0] write_data,
  input  logic                 line_sample,
  input  logic                 q_full,
  output logic                 push,
  output item_t                item
);

  kind_t kind;

  always_comb begin
    case (cmd)
      KIND_WRITE: kind = KIND_WRITE;
      KIND_READ:  kind = KIND_READ;
      KIND_RESET: kind = KIND_RESET;
      default:    kind = KIND_NONE;
    endcase
  end

  // The unused command is dropped here, so the sequencer only sees real requests.
  assign item.start  = start_req && (kind != KIND_NONE);
  assign item.kind   = kind;
  assign item.addr   = reg_addr;
  assign item.wdata  = write_data;
  assign item.sample = line_sample;

  assign req_stall = q_full;
  assign push = req_valid && !q_full;

endmodule

[hdl/twdh_queue.sv]
module twdh_queue import twdh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  q_valid,
  output item_t q_item,
  input  logic  pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "two_wire_debug_host_master_core_assert.svh"

  `TWDH_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QDEPTH), "queue count beyond depth")
  `TWDH_ASSERT_ALWAYS(a_pop_nonempty, !pop || count != '0, "pop from an empty queue")

endmodule

[hdl/twdh_back.sv]
module twdh_back import twdh_pkg::*; #(
  parameter int RESET_CLOCKS = RESET_CLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  clock_level,
  output logic                  data_drive_low,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [DATA_BITS-1:0]  read_data,
  output logic                  status
);

  localparam int BIT_MAX = (TOTAL_BITS > RESET_CLOCKS) ? TOTAL_BITS : RESET_CLOCKS;
  localparam int BIT_W = $clog2(BIT_MAX + 1);

  // Timing registers and the segment lengths derived from them.
  logic [TPU_W-1:0]  ticks_per_unit, ticks_per_unit_next;
  logic [HBU_W-1:0]  half_bit_units, half_bit_units_next;
  logic [TPU_W-1:0]  tpu_eff;
  logic [HBU_W-1:0]  hbu_eff;
  logic [TPU_W-1:0]  lim_unit;
  logic [TPU_W:0]    lim_two;
  logic [TICK_W-1:0] lim_half;

  // Sequencer state.
  phase_t               phase, phase_next;
  logic [BIT_W-1:0]     bit_count, bit_count_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [DATA_BITS-1:0] shift_word, shift_word_next;
  logic                 parity_acc, parity_acc_next;
  logic [ADDR_BITS-1:0] latched_addr, latched_addr_next;
  kind_t                latched_kind, latched_kind_next;
  logic [DATA_BITS-1:0] received_word, received_word_next;
  logic                 last_status, last_status_next;

  // Per-tick working values.
  phase_t            ph_cur;
  logic [TICK_W-1:0] tick_cur;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] seg_lim;
  logic              seg_end;
  logic [BIT_W-1:0]  bit_inc;
  logic [ADDR_IDX_W-1:0] addr_sel;
  logic              op_bit;
  logic              lvl;
  logic              clk_lvl, dlow, busy, done;

  assign cfg_ready = 1'b1;

  always_comb begin
    ticks_per_unit_next = ticks_per_unit;
    half_bit_units_next = half_bit_units;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TICKS_PER_UNIT: ticks_per_unit_next = cfg_data;
        CFG_HALF_BIT_UNITS: half_bit_units_next = cfg_data[HBU_W-1:0];
        default: ;
      endcase
    end
    tpu_eff = (ticks_per_unit_next == '0) ? TPU_W'(1) : ticks_per_unit_next;
    hbu_eff = (half_bit_units_next == '0) ? HBU_W'(1) : half_bit_units_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TPU_RESET;
      half_bit_units <= HBU_RESET;
      lim_unit <= TPU_RESET;
      lim_two <= {TPU_RESET, 1'b0};
      lim_half <= TICK_W'(HBU_RESET) * TICK_W'(TPU_RESET);
    end else begin
      ticks_per_unit <= ticks_per_unit_next;
      half_bit_units <= half_bit_units_next;
      lim_unit <= tpu_eff;
      lim_two <= {tpu_eff, 1'b0};
      lim_half <= TICK_W'(hbu_eff) * TICK_W'(tpu_eff);
    end
  end

  assign pop = q_valid && (!res_valid || !res_stall);

  // Level put on the data line for the current frame bit (1 = released).
  always_comb begin
    op_bit = (latched_kind == KIND_WRITE);
    addr_sel = ADDR_IDX_W'(ADDR_BITS - 1) - bit_count[ADDR_IDX_W-1:0];
    if (bit_count < BIT_W'(ADDR_BITS)) begin
      lvl = latched_addr[addr_sel];
    end else if (bit_count == BIT_W'(ADDR_BITS)) begin
      lvl = op_bit;
    end else if (bit_count == BIT_W'(ADDR_BITS + 1)) begin
      lvl = (^latched_addr) ^ op_bit;
    end else if (bit_count < BIT_W'(DATA_FIRST)) begin
      lvl = bit_count[0];
    end else if (latched_kind == KIND_READ && bit_count <= BIT_W'(DATA_PAR)) begin
      lvl = 1'b1;
    end else if (bit_count < BIT_W'(DATA_PAR)) begin
      lvl = shift_word[DATA_BITS-1];
    end else if (bit_count == BIT_W'(DATA_PAR)) begin
      lvl = parity_acc;
    end else begin
      lvl = (bit_count != BIT_W'(TRAILER_LOW));
    end
  end

  always_comb begin
    phase_next = phase;
    bit_count_next = bit_count;
    shift_word_next = shift_word;
    parity_acc_next = parity_acc;
    latched_addr_next = latched_addr;
    latched_kind_next = latched_kind;
    received_word_next = received_word;
    last_status_next = last_status;
    ph_cur = phase;
    tick_cur = tick_count;
    clk_lvl = 1'b1;
    dlow = 1'b0;
    busy = 1'b0;
    done = 1'b0;
    bit_inc = bit_count + 1'b1;

    if (q_item.start && phase == PH_IDLE) begin
      latched_kind_next = q_item.kind;
      latched_addr_next = q_item.addr;
      shift_word_next = (q_item.kind == KIND_WRITE) ? q_item.wdata : '0;
      parity_acc_next = 1'b0;
      bit_count_next = '0;
      tick_cur = '0;
      ph_cur = (q_item.kind == KIND_RESET) ? PH_RST_PRE : PH_START_A;
    end

    case (ph_cur)
      PH_START_A, PH_STOP_B:   seg_lim = TICK_W'(lim_two);
      PH_BIT_LOW, PH_BIT_HIGH: seg_lim = lim_half;
      default:                 seg_lim = TICK_W'(lim_unit);
    endcase
    tick_inc = tick_cur + 1'b1;
    seg_end = (tick_inc >= seg_lim);
    phase_next = ph_cur;
    tick_count_next = tick_cur;

    if (ph_cur != PH_IDLE) begin
      busy = 1'b1;
      case (ph_cur)
        PH_START_B:  dlow = 1'b1;
        PH_START_C:  begin
          clk_lvl = 1'b0;
          dlow = 1'b1;
        end
        PH_BIT_LOW:  begin
          clk_lvl = 1'b0;
          dlow = ~lvl;
        end
        PH_BIT_HIGH: dlow = ~lvl;
        PH_RST_LOW:  clk_lvl = 1'b0;
        PH_STOP_A, PH_STOP_B: dlow = 1'b1;
        default: ;
      endcase

      tick_count_next = seg_end ? '0 : tick_inc;
      if (seg_end) begin
        case (ph_cur)
          PH_START_A: phase_next = PH_START_B;
          PH_START_B: phase_next = PH_START_C;
          PH_START_C: begin
            bit_count_next = '0;
            phase_next = PH_BIT_LOW;
          end
          PH_BIT_LOW: phase_next = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            if (bit_count >= BIT_W'(DATA_FIRST) && bit_count < BIT_W'(DATA_PAR)) begin
              if (latched_kind == KIND_READ) begin
                shift_word_next = {shift_word[DATA_BITS-2:0], q_item.sample};
                parity_acc_next = parity_acc ^ q_item.sample;
              end else begin
                parity_acc_next = parity_acc ^ shift_word[DATA_BITS-1];
                shift_word_next = {shift_word[DATA_BITS-2:0], 1'b0};
              end
            end else if (bit_count == BIT_W'(DATA_PAR) && latched_kind == KIND_READ) begin
              parity_acc_next = parity_acc ^ q_item.sample;
            end
            bit_count_next = bit_inc;
            phase_next = (bit_inc >= BIT_W'(TOTAL_BITS)) ? PH_STOP_A : PH_BIT_LOW;
          end
          PH_RST_PRE: begin
            bit_count_next = '0;
            phase_next = PH_RST_LOW;
          end
          PH_RST_LOW: phase_next = PH_RST_HIGH;
          PH_RST_HIGH: begin
            bit_count_next = bit_inc;
            phase_next = (bit_inc >= BIT_W'(RESET_CLOCKS)) ? PH_STOP_A : PH_RST_LOW;
          end
          PH_STOP_A: phase_next = PH_STOP_B;
          PH_STOP_B: phase_next = PH_STOP_C;
          default: begin
            done = 1'b1;
            if (latched_kind == KIND_READ) begin
              received_word_next = shift_word;
              last_status_next = parity_acc;
            end else begin
              last_status_next = 1'b0;
            end
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_count <= '0;
      tick_count <= '0;
      shift_word <= '0;
      parity_acc <= 1'b0;
      latched_addr <= '0;
      latched_kind <= KIND_WRITE;
      received_word <= '0;
      last_status <= 1'b0;
    end else if (pop) begin
      phase <= phase_next;
      bit_count <= bit_count_next;
      tick_count <= tick_count_next;
      shift_word <= shift_word_next;
      parity_acc <= parity_acc_next;
      latched_addr <= latched_addr_next;
      latched_kind <= latched_kind_next;
      received_word <= received_word_next;
      last_status <= last_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      clock_level <= clk_lvl;
      data_drive_low <= dlow;
      busy_res <= busy;
      done_res <= done;
      read_data <= received_word_next;
      status <= last_status_next;
    end
  end

`include "two_wire_debug_host_master_core_assert.svh"

  `TWDH_ASSERT_ALWAYS(a_done_busy, !res_valid || !done_res || busy_res, "done without busy")
  `TWDH_ASSERT_NEXT(a_stall_freeze, res_valid && res_stall, res_valid && $stable(phase), "sequencer moved while result stalled")
  `TWDH_ASSERT_ALWAYS(a_idle_tick, phase != PH_IDLE || tick_count == '0, "idle with a running tick count")

endmodule
